// File: src/arp_pkg.sv
`default_nettype none

package arp_pkg;

    // Relocation type numbers as published for AArch64 ELF.
    localparam logic [15:0] RT_ABS64       = 16'd257;
    localparam logic [15:0] RT_ABS32       = 16'd258;
    localparam logic [15:0] RT_PREL32      = 16'd261;
    localparam logic [15:0] RT_MOVW_G0_NC  = 16'd264;
    localparam logic [15:0] RT_MOVW_G1_NC  = 16'd266;
    localparam logic [15:0] RT_MOVW_G2_NC  = 16'd268;
    localparam logic [15:0] RT_MOVW_G3     = 16'd269;
    localparam logic [15:0] RT_ADR_PG_HI21 = 16'd275;
    localparam logic [15:0] RT_ADD_LO12_NC = 16'd277;
    localparam logic [15:0] RT_JUMP26      = 16'd282;
    localparam logic [15:0] RT_CALL26      = 16'd283;
    localparam logic [15:0] RT_GOT_PAGE    = 16'd311;
    localparam logic [15:0] RT_GOT_LO12_NC = 16'd312;
    localparam logic [15:0] RT_COPY        = 16'd1024;
    localparam logic [15:0] RT_GLOB_DAT    = 16'd1025;
    localparam logic [15:0] RT_JUMP_SLOT   = 16'd1026;

    localparam logic [1:0] SZ_NONE  = 2'd0;
    localparam logic [1:0] SZ_FOUR  = 2'd1;
    localparam logic [1:0] SZ_EIGHT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;

    // Instruction field keep masks.
    localparam logic [31:0] MOVW_KEEP_MASK = 32'hffe0001f;
    localparam logic [31:0] ADRP_KEEP_MASK = 32'h9f00001f;
    localparam logic [31:0] ADD_KEEP_MASK  = 32'hffc003ff;
    localparam logic [31:0] LDR_KEEP_MASK  = 32'hfff803ff;
    localparam logic [31:0] BRANCH_OPCODE  = 32'h14000000;

    typedef struct packed {
        logic [63:0] new_word;
        logic [1:0]  write_size;
        logic [1:0]  status;
    } arp_result_t;

endpackage

`default_nettype wire

// File: src/arp_core.sv
`default_nettype none

module arp_core
    import arp_pkg::*;
(
    input  wire logic [15:0] reloc_code,
    input  wire logic [31:0] old_word,
    input  wire logic [63:0] place_addr,
    input  wire logic [63:0] sym_value,
    input  wire logic [63:0] got_entry_addr,
    input  wire logic [63:0] addend,
    output arp_result_t      result
);

    logic [63:0] sym_delta;
    logic [63:0] sym_page_delta;
    logic [63:0] got_page_delta;
    logic [63:0] glob_value;
    logic        sym_page_fits;
    logic        got_page_fits;
    logic        branch_fits;
    logic [31:0] sym_adrp_word;
    logic [31:0] got_adrp_word;
    logic [31:0] branch_word;
    logic [63:0] res;
    logic [1:0]  size;
    logic [1:0]  status;

    function automatic logic [31:0] put_movw(input logic [31:0] word,
                                             input logic [15:0] chunk);
        put_movw = (word & MOVW_KEEP_MASK) | {11'd0, chunk, 5'd0};
    endfunction

    function automatic logic [31:0] put_adrp(input logic [31:0] word,
                                             input logic [63:0] delta);
        put_adrp = (word & ADRP_KEEP_MASK) | {1'b0, delta[1:0], 5'd0,
                                              delta[20:2], 5'd0};
    endfunction

    assign sym_delta      = sym_value - place_addr;
    assign sym_page_delta = {12'd0, sym_value[63:12]} - {12'd0, place_addr[63:12]};
    assign got_page_delta = {12'd0, got_entry_addr[63:12]} - {12'd0, place_addr[63:12]};
    assign glob_value     = sym_value - addend;

    // A page delta fits when it sign-extends from 21 bits.
    assign sym_page_fits = (&sym_page_delta[63:20]) || !(|sym_page_delta[63:20]);
    assign got_page_fits = (&got_page_delta[63:20]) || !(|got_page_delta[63:20]);

    // A branch offset must be word aligned and sign-extend from 28 bits.
    assign branch_fits = (sym_delta[1:0] == 2'b00)
                         && ((&sym_delta[63:27]) || !(|sym_delta[63:27]));

    assign sym_adrp_word = put_adrp(old_word, sym_page_delta);
    assign got_adrp_word = put_adrp(old_word, got_page_delta);
    assign branch_word   = BRANCH_OPCODE | {(reloc_code == RT_CALL26), 5'd0,
                                            sym_delta[27:2]};

    always_comb
    begin
        res    = 64'd0;
        size   = SZ_FOUR;
        status = ST_OK;
        unique case (reloc_code) inside
            RT_ABS64:
            begin
                res  = sym_value;
                size = SZ_EIGHT;
            end
            RT_ABS32:       res = {32'd0, sym_value[31:0]};
            RT_PREL32:      res = {32'd0, sym_delta[31:0]};
            RT_MOVW_G0_NC:  res = {32'd0, put_movw(old_word, sym_value[15:0])};
            RT_MOVW_G1_NC:  res = {32'd0, put_movw(old_word, sym_value[31:16])};
            RT_MOVW_G2_NC:  res = {32'd0, put_movw(old_word, sym_value[47:32])};
            RT_MOVW_G3:     res = {32'd0, put_movw(old_word, sym_value[63:48])};
            RT_ADR_PG_HI21:
            begin
                if (sym_page_fits)
                    res = {32'd0, sym_adrp_word};
                else
                    status = ST_OVERFLOW;
            end
            RT_ADD_LO12_NC:
                res = {32'd0, (old_word & ADD_KEEP_MASK)
                              | {10'd0, sym_value[11:0], 10'd0}};
            RT_JUMP26, RT_CALL26:
            begin
                if (branch_fits)
                    res = {32'd0, branch_word};
                else
                    status = ST_OVERFLOW;
            end
            RT_GOT_PAGE:
            begin
                if (got_page_fits)
                    res = {32'd0, got_adrp_word};
                else
                    status = ST_OVERFLOW;
            end
            RT_GOT_LO12_NC:
                res = {32'd0, (old_word & LDR_KEEP_MASK)
                              | {13'd0, got_entry_addr[11:3], 10'd0}};
            RT_COPY:        size = SZ_NONE;
            RT_GLOB_DAT, RT_JUMP_SLOT:
            begin
                res  = glob_value;
                size = SZ_EIGHT;
            end
            default:        status = ST_UNKNOWN;
        endcase

        // Any failure suppresses the write entirely.
        if (status != ST_OK)
        begin
            res  = 64'd0;
            size = SZ_NONE;
        end

        result.new_word   = res;
        result.write_size = size;
        result.status     = status;
    end

endmodule

`default_nettype wire

// File: src/aarch64_reloc_patcher.sv
// Path: an accepted item is registered, then its result is registered for output.
// Throughput: one item per cycle while out_stall is low; the input and result
// registers form a two-stage pipeline, so a new item is taken while a result waits.
// Reset: rst_n is asynchronous, active low; it empties both stages, and
// the block is ready for an item as soon as reset is released.
`default_nettype none

module aarch64_reloc_patcher
    import arp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] reloc_code,
    input  wire logic [31:0] old_word,
    input  wire logic [63:0] place_addr,
    input  wire logic [63:0] sym_value,
    input  wire logic [63:0] got_entry_addr,
    input  wire logic [63:0] addend,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      new_word,
    output logic [1:0]       write_size,
    output logic [1:0]       status
);

    logic        stage_valid_reg;
    logic [15:0] type_reg;
    logic [31:0] word_reg;
    logic [63:0] place_reg;
    logic [63:0] sym_reg;
    logic [63:0] got_reg;
    logic [63:0] addend_reg;
    logic        out_valid_reg;
    arp_result_t result_next;
    arp_result_t result_reg;
    logic        out_advance;
    logic        in_advance;

    // The result register can load whenever it is empty or being drained.
    assign out_advance = !out_valid_reg || !out_stall;
    assign in_advance  = !stage_valid_reg || out_advance;
    assign in_stall    = !in_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_advance)
            stage_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && in_valid)
        begin
            type_reg   <= reloc_code;
            word_reg   <= old_word;
            place_reg  <= place_addr;
            sym_reg    <= sym_value;
            got_reg    <= got_entry_addr;
            addend_reg <= addend;
        end
    end

    arp_core u_core (
        .reloc_code     (type_reg),
        .old_word       (word_reg),
        .place_addr     (place_reg),
        .sym_value      (sym_reg),
        .got_entry_addr (got_reg),
        .addend         (addend_reg),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_advance)
            out_valid_reg <= stage_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && stage_valid_reg)
            result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign new_word   = result_reg.new_word;
    assign write_size = result_reg.write_size;
    assign status     = result_reg.status;

endmodule

`default_nettype wire

// File: src/arp_checker.sv
`default_nettype none

module arp_checker
    import arp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [63:0] new_word,
    input wire logic [1:0]  write_size,
    input wire logic [1:0]  status
);

    // A result that is stalled stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // An accepted item is always followed by a valid output after the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ##1 out_valid)
        else $error("accepted item did not reach the output");

    // A failed relocation never writes and carries a zero value.
    a_fail_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (write_size == SZ_NONE) && (new_word == 64'd0))
        else $error("failed relocation requests a write");

    // Four-byte results have a clear upper half.
    a_four_upper: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (write_size == SZ_FOUR) |-> (new_word[63:32] == 32'd0))
        else $error("four-byte result has upper bits set");

endmodule

bind aarch64_reloc_patcher arp_checker u_arp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .new_word   (new_word),
    .write_size (write_size),
    .status     (status)
);

`default_nettype wire

// File: tb/sv/aarch64_reloc_patcher_tb.sv
`timescale 1ns / 1ps

import arp_pkg::*;

typedef struct {
    logic [15:0] rtype;
    logic [31:0] word;
    logic [63:0] place;
    logic [63:0] sym;
    logic [63:0] got;
    logic [63:0] addend;
} reloc_req_t;

class reloc_scoreboard;
    arp_result_t pending_patches[$];
    int unsigned noted = 0;
    int unsigned checked = 0;
    int unsigned errors = 0;
    int unsigned n_written = 0;
    int unsigned n_overflow = 0;
    int unsigned n_unknown = 0;

    function logic [63:0] movw_patch(logic [31:0] word, logic [15:0] chunk);
        return {32'd0, (word & MOVW_KEEP_MASK) | {11'd0, chunk, 5'd0}};
    endfunction

    // Returns zero when the signed page delta does not fit in 21 bits.
    function bit adrp_patch(logic [31:0] word, logic [63:0] target, logic [63:0] place,
                            output logic [63:0] patched);
        logic [63:0] delta;
        delta = (target >> 12) - (place >> 12);
        patched = '0;
        if (((delta + 64'h10_0000) >> 21) != 64'd0)
            return 1'b0;
        patched = {32'd0, (word & ADRP_KEEP_MASK) | {8'd0, delta[20:2], 5'd0}
                          | {1'b0, delta[1:0], 29'd0}};
        return 1'b1;
    endfunction

    function arp_result_t patch_for(reloc_req_t req);
        arp_result_t r;
        logic [63:0] d;
        logic [31:0] br;
        r.new_word = '0;
        r.write_size = SZ_FOUR;
        r.status = ST_OK;
        case (req.rtype)
            RT_ABS64:
            begin
                r.new_word = req.sym;
                r.write_size = SZ_EIGHT;
            end
            RT_ABS32:
                r.new_word = {32'd0, req.sym[31:0]};
            RT_PREL32:
            begin
                d = req.sym - req.place;
                r.new_word = {32'd0, d[31:0]};
            end
            RT_MOVW_G0_NC:
                r.new_word = movw_patch(req.word, req.sym[15:0]);
            RT_MOVW_G1_NC:
                r.new_word = movw_patch(req.word, req.sym[31:16]);
            RT_MOVW_G2_NC:
                r.new_word = movw_patch(req.word, req.sym[47:32]);
            RT_MOVW_G3:
                r.new_word = movw_patch(req.word, req.sym[63:48]);
            RT_ADR_PG_HI21:
                if (!adrp_patch(req.word, req.sym, req.place, r.new_word))
                    r.status = ST_OVERFLOW;
            RT_ADD_LO12_NC:
                r.new_word = {32'd0, (req.word & ADD_KEEP_MASK)
                                     | {10'd0, req.sym[11:0], 10'd0}};
            RT_JUMP26, RT_CALL26:
            begin
                d = req.sym - req.place;
                // Out of the signed 28-bit window or not word aligned.
                if (((d + 64'h800_0000) & ~64'hfff_fffc) != 64'd0)
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    br = BRANCH_OPCODE | {6'd0, d[27:2]};
                    if (req.rtype == RT_CALL26)
                        br[31] = 1'b1;
                    r.new_word = {32'd0, br};
                end
            end
            RT_GOT_PAGE:
                if (!adrp_patch(req.word, req.got, req.place, r.new_word))
                    r.status = ST_OVERFLOW;
            RT_GOT_LO12_NC:
                r.new_word = {32'd0, (req.word & LDR_KEEP_MASK)
                                     | {13'd0, req.got[11:3], 10'd0}};
            RT_COPY:
                r.write_size = SZ_NONE;
            RT_GLOB_DAT, RT_JUMP_SLOT:
            begin
                r.new_word = req.sym - req.addend;
                r.write_size = SZ_EIGHT;
            end
            default:
                r.status = ST_UNKNOWN;
        endcase
        if (r.status != ST_OK)
        begin
            r.new_word = '0;
            r.write_size = SZ_NONE;
        end
        return r;
    endfunction

    function void note_request(reloc_req_t req);
        pending_patches.push_back(patch_for(req));
        noted++;
    endfunction

    function void check_patch(arp_result_t seen);
        arp_result_t want;
        if (pending_patches.size() == 0)
        begin
            $error("unexpected result: new_word %h write_size %0d status %0d",
                   seen.new_word, seen.write_size, seen.status);
            errors++;
            return;
        end
        want = pending_patches.pop_front();
        checked++;
        case (want.status)
            ST_OK:       n_written++;
            ST_OVERFLOW: n_overflow++;
            default:     n_unknown++;
        endcase
        if (seen.new_word !== want.new_word)
        begin
            $error("new_word: expected %h, got %h", want.new_word, seen.new_word);
            errors++;
        end
        if (seen.write_size !== want.write_size)
        begin
            $error("write_size: expected %0d, got %0d", want.write_size, seen.write_size);
            errors++;
        end
        if (seen.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            errors++;
        end
    endfunction
endclass

module aarch64_reloc_patcher_tb;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned HOLD_AFTER   = 500;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 8;

    localparam logic [15:0] KNOWN_TYPES [16] = '{
        RT_ABS64, RT_ABS32, RT_PREL32, RT_MOVW_G0_NC, RT_MOVW_G1_NC, RT_MOVW_G2_NC,
        RT_MOVW_G3, RT_ADR_PG_HI21, RT_ADD_LO12_NC, RT_JUMP26, RT_CALL26, RT_GOT_PAGE,
        RT_GOT_LO12_NC, RT_COPY, RT_GLOB_DAT, RT_JUMP_SLOT
    };

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_EVERY_THIRD
    } stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] reloc_code = '0;
    logic [31:0] old_word = '0;
    logic [63:0] place_addr = '0;
    logic [63:0] sym_value = '0;
    logic [63:0] got_entry_addr = '0;
    logic [63:0] addend = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] new_word;
    logic [1:0]  write_size;
    logic [1:0]  status;

    reloc_scoreboard sb = new;
    int unsigned burst_left = 0;

    aarch64_reloc_patcher i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .reloc_code     (reloc_code),
        .old_word       (old_word),
        .place_addr     (place_addr),
        .sym_value      (sym_value),
        .got_entry_addr (got_entry_addr),
        .addend         (addend),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .new_word       (new_word),
        .write_size     (write_size),
        .status         (status)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timed out after %0d cycles", CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    function automatic reloc_req_t make_req(logic [15:0] rtype, logic [31:0] word,
                                            logic [63:0] place, logic [63:0] sym,
                                            logic [63:0] got, logic [63:0] add);
        reloc_req_t req;
        req.rtype = rtype;
        req.word = word;
        req.place = place;
        req.sym = sym;
        req.got = got;
        req.addend = add;
        return req;
    endfunction

    // Offsets that land near the branch and page windows, inside and just outside.
    function automatic logic [63:0] near_offset();
        logic [63:0] off;
        case ($urandom_range(0, 7))
            0, 1:    off = {$urandom, $urandom};
            2, 3, 4: off = 64'($urandom_range(0, 32'h7ff_ffff)) & ~64'd3;
            5:       off = {30'd0, 2'($urandom), $urandom};
            6:       off = 64'h800_0000 + 64'($urandom_range(0, 15)) - 64'd8;
            default: off = 64'hffff_f000 + 64'($urandom_range(0, 32'h2000));
        endcase
        if ($urandom_range(0, 1) == 1)
            off = -off;
        return off;
    endfunction

    function automatic reloc_req_t random_request();
        reloc_req_t req;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            req.rtype = 16'($urandom);
        else if (pick == 1)
            req.rtype = 16'($urandom_range(250, 1040));
        else
            req.rtype = KNOWN_TYPES[$urandom_range(0, 15)];
        req.word = $urandom;
        req.place = {$urandom, $urandom};
        req.sym = req.place + near_offset();
        req.got = req.place + near_offset();
        if ($urandom_range(0, 1) == 1)
            req.addend = {$urandom, $urandom};
        else
            req.addend = 64'($urandom_range(0, 4095));
        return req;
    endfunction

    task automatic offer(input reloc_req_t req);
        in_valid <= 1'b1;
        reloc_code <= req.rtype;
        old_word <= req.word;
        place_addr <= req.place;
        sym_value <= req.sym;
        got_entry_addr <= req.got;
        addend <= req.addend;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(req);
    endtask

    // Items go out in bursts; between bursts valid drops for a random gap.
    task automatic send_paced(input reloc_req_t req);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        offer(req);
        burst_left--;
    endtask

    task automatic run_directed();
        send_paced(make_req(RT_ABS64, '0, '0, '1, '0, '0));
        send_paced(make_req(RT_ABS64, '1, '1, '0, '1, '1));
        send_paced(make_req(RT_ABS32, '1, '0, 64'hffff_ffff_8000_0001, '0, '0));
        // PREL32 wraps below zero.
        send_paced(make_req(RT_PREL32, '0, 64'd1, '0, '0, '0));
        send_paced(make_req(RT_MOVW_G0_NC, '1, '0, 64'h1234_5678_9abc_def0, '0, '0));
        send_paced(make_req(RT_MOVW_G1_NC, '0, '0, 64'h1234_5678_9abc_def0, '0, '0));
        send_paced(make_req(RT_MOVW_G2_NC, '1, '0, 64'h1234_5678_9abc_def0, '0, '0));
        send_paced(make_req(RT_MOVW_G3, '0, '0, '1, '0, '0));
        // Page deltas at both edges of the 21-bit window.
        send_paced(make_req(RT_ADR_PG_HI21, '1, '0, 64'h0_ffff_ffff, '0, '0));
        send_paced(make_req(RT_ADR_PG_HI21, '1, '0, 64'h1_0000_0000, '0, '0));
        send_paced(make_req(RT_ADR_PG_HI21, '0, 64'h1_0000_0000, '0, '0, '0));
        send_paced(make_req(RT_ADR_PG_HI21, '0, 64'h1_0000_1000, '0, '0, '0));
        send_paced(make_req(RT_ADD_LO12_NC, '1, '0, 64'hfff, '0, '0));
        // Branch offsets at both edges, and one that is not word aligned.
        send_paced(make_req(RT_JUMP26, '1, '0, 64'h7ff_fffc, '0, '0));
        send_paced(make_req(RT_JUMP26, '1, '0, 64'h800_0000, '0, '0));
        send_paced(make_req(RT_CALL26, '0, 64'h800_0000, '0, '0, '0));
        send_paced(make_req(RT_CALL26, '0, 64'h800_0004, '0, '0, '0));
        send_paced(make_req(RT_CALL26, '0, '0, 64'd2, '0, '0));
        send_paced(make_req(RT_GOT_PAGE, '1, 64'hffff_ffff_ffff_f000, '0, '0, '0));
        send_paced(make_req(RT_GOT_LO12_NC, '0, '0, '0, '1, '0));
        send_paced(make_req(RT_COPY, '1, '1, '1, '1, '1));
        send_paced(make_req(RT_GLOB_DAT, '0, '0, '0, '0, 64'd1));
        send_paced(make_req(RT_JUMP_SLOT, '0, '0, '1, '0, '1));
        send_paced(make_req(16'd0, '1, '1, '1, '1, '1));
        send_paced(make_req(16'hffff, '0, '0, '0, '0, '0));
        send_paced(make_req(16'd1027, '1, '0, '1, '0, '1));
    endtask

    initial
    begin : receiver
        stall_mode_t mode;
        int unsigned mode_left;
        int unsigned hold_left;
        bit held;
        logic next_stall;
        arp_result_t seen;
        mode = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                seen = {new_word, write_size, status};
                sb.check_patch(seen);
            end
            // One long hold-off lets the pipeline fill and push back on the sender.
            if (!held && sb.noted >= HOLD_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                STALL_NONE:        next_stall = 1'b0;
                STALL_LIGHT:       next_stall = ($urandom_range(0, 3) == 0);
                STALL_HEAVY:       next_stall = ($urandom_range(0, 3) != 0);
                STALL_EVERY_THIRD: next_stall = (mode_left % 3 == 0);
                default:           next_stall = 1'b0;
            endcase
            if (hold_left != 0)
            begin
                next_stall = 1'b1;
                hold_left--;
            end
            out_stall <= next_stall;
        end
    end

    initial
    begin : stimulus
        reloc_req_t req;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        repeat (RANDOM_ITEMS)
        begin
            req = random_request();
            send_paced(req);
        end
        in_valid <= 1'b0;
        while (sb.pending_patches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d relocations: %0d patched or copied, %0d out of range, %0d unknown",
                 sb.checked, sb.n_written, sb.n_overflow, sb.n_unknown);
        $display("Traffic included bursty input, mixed output stalls and a %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
